@@ hdl/lsb_first_bit_packer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the LSB-first bit packer
// Shorthand for clocked properties that are disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef LSB_FIRST_BIT_PACKER_ASSERT_SVH
`define LSB_FIRST_BIT_PACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/lbp_pkg.sv @@
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared widths, request codes and inter-module types of the bit packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbp_pkg;

    localparam int BYTE_W     = 8;
    localparam int DATA_W     = 32;
    localparam int WIDTH_W    = 6;
    localparam int HELD_W     = 7;
    localparam int CNT_W      = 3;
    localparam int MAX_BYTES  = 4;
    localparam int IDX_W      = $clog2(MAX_BYTES);
    localparam int ACC_W      = DATA_W + HELD_W;
    localparam int REQ_W      = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

    // Request codes carried on the input tuser.
    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_ALIGN = 2'd1,
        REQ_FLUSH = 2'd2
    } req_t;

    // One queued job: up to four bytes, earliest byte in the low bits.
    typedef struct packed {
        logic [DATA_W-1:0] bytes;
        logic [IDX_W-1:0]  last_idx;
    } job_t;

    // Queue status seen by the front, the back and the checks.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // Front status for the checks.
    typedef struct packed {
        logic [CNT_W-1:0] pend_cnt;
    } front_stat_t;

endpackage

`default_nettype wire

@@ hdl/lbp_front.sv @@
// ----------------------------------------------------------------------------
// lbp_front
// Accepts requests, merges written bits with the held bits and queues jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbp_front
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [lbp_pkg::REQ_W-1:0]   req_type,
    input  wire logic [lbp_pkg::DATA_W-1:0]  data_value,
    input  wire logic [lbp_pkg::WIDTH_W-1:0] field_width,
    input  wire lbp_pkg::queue_stat_t        queue_stat,
    output logic                             push,
    output lbp_pkg::job_t                    push_job,
    output lbp_pkg::front_stat_t             front_stat
);

    logic [lbp_pkg::HELD_W-1:0]  pend_bits_reg;
    logic [lbp_pkg::HELD_W-1:0]  pend_bits_next;
    logic [lbp_pkg::CNT_W-1:0]   pend_cnt_reg;
    logic [lbp_pkg::CNT_W-1:0]   pend_cnt_next;

    logic                        s_fire;
    logic [lbp_pkg::DATA_W:0]    width_lim;
    logic [lbp_pkg::DATA_W-1:0]  width_mask;
    logic [lbp_pkg::ACC_W-1:0]   acc;
    logic [lbp_pkg::WIDTH_W-1:0] total;
    logic [lbp_pkg::CNT_W-1:0]   nbytes;
    logic [lbp_pkg::HELD_W-1:0]  rest_bits;
    logic                        width_ok;

    // A request is taken whenever the queue has room for a job.
    assign s_tready = !queue_stat.full;
    assign s_fire   = s_tvalid && s_tready;

    // Mask the value to the field width; a width of 32 keeps every bit.
    assign width_lim  = (lbp_pkg::DATA_W + 1)'(1) << field_width;
    assign width_mask = width_lim[lbp_pkg::DATA_W-1:0] - 1'b1;
    assign width_ok   = (field_width <= lbp_pkg::WIDTH_W'(lbp_pkg::DATA_W));

    // Place the new bits above the held ones and count completed bytes.
    assign acc = {{(lbp_pkg::ACC_W - lbp_pkg::HELD_W){1'b0}}, pend_bits_reg}
               | (lbp_pkg::ACC_W'(data_value & width_mask) << pend_cnt_reg);
    assign total  = lbp_pkg::WIDTH_W'(pend_cnt_reg) + field_width;
    assign nbytes = total[lbp_pkg::WIDTH_W-1:3];

    // Bits left over after the completed bytes are removed.
    always_comb
    begin
        case (nbytes)
            3'd0:    rest_bits = acc[0 +: lbp_pkg::HELD_W];
            3'd1:    rest_bits = acc[8 +: lbp_pkg::HELD_W];
            3'd2:    rest_bits = acc[16 +: lbp_pkg::HELD_W];
            3'd3:    rest_bits = acc[24 +: lbp_pkg::HELD_W];
            default: rest_bits = acc[32 +: lbp_pkg::HELD_W];
        endcase
    end

    // Request decoder: next held state and the job to queue.
    always_comb
    begin
        pend_bits_next     = pend_bits_reg;
        pend_cnt_next      = pend_cnt_reg;
        push               = 1'b0;
        push_job.bytes     = acc[lbp_pkg::DATA_W-1:0];
        push_job.last_idx  = lbp_pkg::IDX_W'(nbytes - 3'd1);
        unique case (req_type) inside
            lbp_pkg::REQ_WRITE:
            begin
                if (width_ok)
                begin
                    pend_bits_next = rest_bits;
                    pend_cnt_next  = total[lbp_pkg::CNT_W-1:0];
                    push           = s_fire && (nbytes != '0);
                end
            end
            lbp_pkg::REQ_ALIGN, lbp_pkg::REQ_FLUSH:
            begin
                // Both emit the held bits zero-padded to one byte.
                push_job.bytes    = {{(lbp_pkg::DATA_W - lbp_pkg::HELD_W){1'b0}},
                                     pend_bits_reg};
                push_job.last_idx = '0;
                pend_bits_next    = '0;
                pend_cnt_next     = '0;
                push              = s_fire && (pend_cnt_reg != '0);
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // Held bits change only when a beat is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end
        else if (s_fire)
        begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

    assign front_stat.pend_cnt = pend_cnt_reg;

endmodule

`default_nettype wire

@@ hdl/lbp_queue.sv @@
// ----------------------------------------------------------------------------
// lbp_queue
// Two-entry job queue that decouples request intake from byte output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbp_queue
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire lbp_pkg::job_t        push_job,
    input  wire logic                 pop,
    output lbp_pkg::job_t             pop_job,
    output lbp_pkg::queue_stat_t      queue_stat
);

    lbp_pkg::job_t               slot_reg [lbp_pkg::QUEUE_DEPTH];
    logic [lbp_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [lbp_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [lbp_pkg::QPTR_W:0]    fill_reg;
    logic [lbp_pkg::QPTR_W:0]    fill_next;
    logic                        do_push;
    logic                        do_pop;

    assign queue_stat.full  = (fill_reg == (lbp_pkg::QPTR_W + 1)'(lbp_pkg::QUEUE_DEPTH));
    assign queue_stat.empty = (fill_reg == '0);
    assign do_push = push && !queue_stat.full;
    assign do_pop  = pop && !queue_stat.empty;
    assign pop_job = slot_reg[rd_ptr_reg];

    // Fill level follows pushes and pops.
    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Job storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lbp_back.sv @@
// ----------------------------------------------------------------------------
// lbp_back
// Takes jobs from the queue and sends their bytes one beat at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbp_back
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire lbp_pkg::job_t               pop_job,
    input  wire lbp_pkg::queue_stat_t        queue_stat,
    output logic                             pop,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [lbp_pkg::BYTE_W-1:0]       m_tdata,
    output logic                             m_tlast
);

    logic                         busy_reg;
    logic [lbp_pkg::DATA_W-1:0]   shift_reg;
    logic [lbp_pkg::IDX_W-1:0]    left_reg;
    logic                         m_fire;
    logic                         job_done;

    assign m_fire   = m_tvalid && m_tready;
    assign job_done = !busy_reg || (m_fire && (left_reg == '0));
    assign pop      = job_done && !queue_stat.empty;

    assign m_tvalid = busy_reg;
    assign m_tdata  = shift_reg[lbp_pkg::BYTE_W-1:0];
    assign m_tlast  = (left_reg == '0);

    // Busy flag and byte counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            left_reg <= '0;
        end
        else if (job_done)
        begin
            busy_reg <= !queue_stat.empty;
            left_reg <= pop_job.last_idx;
        end
        else if (m_fire)
        begin
            left_reg <= left_reg - 1'b1;
        end
    end

    // Output bytes: load a new job or move to the next byte.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            shift_reg <= pop_job.bytes;
        end
        else if (m_fire)
        begin
            shift_reg <= shift_reg >> lbp_pkg::BYTE_W;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lsb_first_bit_packer.sv @@
// ----------------------------------------------------------------------------
// lsb_first_bit_packer
// Packs variable-width fields, least significant bit first, into bytes.
// ----------------------------------------------------------------------------
//  Channel | Direction | tdata                         | tuser       | tlast
//  s_      | in        | data_value, field_width       | req_type    | -
//  m_      | out       | out_byte                      | -           | last_of_run
//
// A request is taken whenever the two-entry job queue has room.
// Output runs at one byte per cycle while m_tready stays high; a write
// completes up to four bytes, and align and flush emit at most one.
// Reset clears the held bits and empties the queue; no clearing pass.
// A stalled output fills the queue, after which s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

`include "lsb_first_bit_packer_assert.svh"

module lsb_first_bit_packer
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [31:0] data_value, [37:32] field_width, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast
);

    logic                  push;
    logic                  pop;
    lbp_pkg::job_t         push_job;
    lbp_pkg::job_t         pop_job;
    lbp_pkg::queue_stat_t  queue_stat;
    lbp_pkg::front_stat_t  front_stat;

    // Request intake and bit merging.
    lbp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .req_type    (s_tuser),
        .data_value  (s_tdata[31:0]),
        .field_width (s_tdata[37:32]),
        .queue_stat  (queue_stat),
        .push        (push),
        .push_job    (push_job),
        .front_stat  (front_stat)
    );

    // Job queue between intake and output.
    lbp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .pop_job    (pop_job),
        .queue_stat (queue_stat)
    );

    // Byte output.
    lbp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_job    (pop_job),
        .queue_stat (queue_stat),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // Checks on queue flow and held state.
    `LBP_ASSERT_NOW(a_no_push_when_full, clk, rst_n, push, !queue_stat.full, "job pushed into full queue")
    `LBP_ASSERT_NEXT(a_flush_clears, clk, rst_n, s_tvalid && s_tready && (s_tuser == lbp_pkg::REQ_FLUSH), front_stat.pend_cnt == '0, "flush left bits pending")
    `LBP_ASSERT_NEXT(a_back_picks_job, clk, rst_n, !m_tvalid && !queue_stat.empty, m_tvalid, "queued job not picked up")

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for lsb_first_bit_packer
// Sends write, align and flush requests and predicts the byte stream that
// they produce. Each output beat is checked against the oldest predicted
// byte. Random idle bursts fall on both sides of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import lbp_pkg::*;

    // The request code that the block ignores.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RAND_REQS    = 106;
    localparam int CYCLE_LIMIT  = 60000;
    localparam int TAIL_CYCLES  = 20;

    // One request to send, with the driver's pacing hints.
    typedef struct {
        logic [REQ_W-1:0]   req;
        logic [DATA_W-1:0]  value;
        logic [WIDTH_W-1:0] width;
        bit                 drain_first;
        bit                 quiet;
    } pack_req_t;

    // One predicted output beat.
    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } out_byte_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [39:0]        s_tdata  = '0;   // [31:0] data_value, [37:32] field_width
    logic [1:0]         s_tuser  = '0;   // [1:0] req_type
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [7:0]         m_tdata;         // [7:0] out_byte
    logic               m_tlast;

    pack_req_t          req_q[$];
    out_byte_t          bytes_due[$];
    pack_req_t          next_req;
    logic [HELD_W-1:0]  held_bits = '0;
    logic [CNT_W-1:0]   held_cnt  = '0;
    int                 total_reqs;
    int                 accepted_cnt;
    int                 checked_cnt;
    int                 error_cnt;
    int                 cycle_cnt;
    int                 gap_left;
    int                 stall_left;
    bit                 quiet_phase;

    lsb_first_bit_packer DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("tb: MISMATCH at cycle %0d: %s", cycle_cnt, msg);
        error_cnt++;
    endtask

    // Appends the low bits of a field above the held bits and predicts every
    // byte that completes, up to four.
    task automatic pack_field(input logic [DATA_W-1:0] value, input int unsigned width);
        logic [ACC_W-1:0]  acc;
        logic [DATA_W-1:0] mask;
        int unsigned       cnt;
        int                n;
        if (width == 0 || width > DATA_W)
            return;
        mask = (width == DATA_W) ? '1 : ((32'd1 << width) - 32'd1);
        acc  = {{DATA_W{1'b0}}, held_bits} | ({{HELD_W{1'b0}}, value & mask} << held_cnt);
        cnt  = held_cnt + width;
        n    = 0;
        while (cnt >= BYTE_W && n < MAX_BYTES)
        begin
            bytes_due.push_back('{acc[BYTE_W-1:0], (cnt - BYTE_W < BYTE_W) || (n == 3)});
            acc = acc >> BYTE_W;
            cnt = cnt - BYTE_W;
            n++;
        end
        held_bits = acc[HELD_W-1:0];
        held_cnt  = cnt[CNT_W-1:0];
    endtask

    // Updates the held bits and the predicted bytes for one accepted request.
    task automatic pack_request(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] value,
                                input logic [WIDTH_W-1:0] width);
        case (req)
            REQ_WRITE: pack_field(value, width);
            REQ_ALIGN:
            begin
                if (held_cnt != 0)
                    pack_field('0, BYTE_W - held_cnt);
            end
            REQ_FLUSH:
            begin
                if (held_cnt != 0)
                begin
                    bytes_due.push_back('{{1'b0, held_bits}, 1'b1});
                    held_bits = '0;
                    held_cnt  = '0;
                end
            end
            default: ;
        endcase
    endtask

    function automatic void add_req(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] value,
                                    input logic [WIDTH_W-1:0] width,
                                    input bit drain_first = 1'b0, input bit quiet = 1'b0);
        req_q.push_back('{req, value, width, drain_first, quiet});
    endfunction

    // Driver: presents queued requests, holds a beat until it is taken, and
    // inserts random idle bursts between beats.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pack_request(s_tuser, s_tdata[31:0], s_tdata[37:32]);
                accepted_cnt++;
            end
            if (s_tvalid && !s_tready)
            begin
                // Beat still waiting; keep it steady.
            end
            else if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (req_q.size() != 0 && (!req_q[0].drain_first || bytes_due.size() == 0))
            begin
                next_req = req_q.pop_front();
                if (next_req.quiet)
                    quiet_phase = 1'b1;
                s_tvalid <= 1'b1;
                s_tuser  <= next_req.req;
                s_tdata  <= {2'b00, next_req.width, next_req.value};
                if (!quiet_phase && $urandom_range(0, 3) == 0)
                    gap_left <= $urandom_range(1, 11);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each output beat against the oldest predicted byte and
    // stalls the output in random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        out_byte_t exp_byte;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (bytes_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
                end
                else
                begin
                    exp_byte = bytes_due.pop_front();
                    checked_cnt++;
                    if (m_tdata !== exp_byte.data)
                        report_mismatch($sformatf("byte %0d: got %02h, want %02h",
                                                  checked_cnt, m_tdata, exp_byte.data));
                    if (m_tlast !== exp_byte.last)
                        report_mismatch($sformatf("byte %0d: last got %0b, want %0b",
                                                  checked_cnt, m_tlast, exp_byte.last));
                end
            end
            if (stall_left != 0 && !quiet_phase)
            begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(0, 10);
                m_tready   <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Cycle limit for the whole run.
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb: timeout after %0d cycles", cycle_cnt);
        $display("tb: done, errors");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int          counted;
        int          pick;
        int unsigned wid;
        logic [31:0] val;

        // Directed part: width extremes, every request kind and the
        // corner cases of align and flush.
        add_req(REQ_WRITE, 32'hFFFF_FFFF, 6'd0);
        add_req(REQ_WRITE, 32'hFFFF_FFFF, 6'd32);
        add_req(REQ_WRITE, 32'h0000_0000, 6'd32);
        add_req(REQ_ALIGN, 32'hFFFF_FFFF, 6'd63);
        add_req(REQ_FLUSH, 32'hFFFF_FFFF, 6'd63);
        add_req(REQ_WRITE, 32'h0000_0005, 6'd3);
        add_req(REQ_WRITE, 32'hA5A5_A5A5, 6'd32);
        add_req(REQ_ALIGN, 32'h1234_5678, 6'd17);
        add_req(REQ_ALIGN, 32'h0, 6'd0);
        add_req(REQ_WRITE, 32'hFFFF_FFFF, 6'd5);
        add_req(REQ_FLUSH, 32'h0, 6'd0);
        add_req(REQ_FLUSH, 32'h0, 6'd0);
        add_req(REQ_WRITE, 32'hFFFF_FFFF, 6'd33);
        add_req(REQ_WRITE, 32'hFFFF_FFFF, 6'd63);
        add_req(REQ_UNUSED, 32'hFFFF_FFFF, 6'd63);
        add_req(REQ_WRITE, 32'h0000_0001, 6'd1);
        add_req(REQ_WRITE, 32'hFFFF_FFFE, 6'd7);
        add_req(REQ_WRITE, 32'h0000_007F, 6'd7);
        add_req(REQ_WRITE, 32'hDEAD_BEEF, 6'd32);
        add_req(REQ_FLUSH, 32'h0, 6'd0, 1'b1);
        add_req(REQ_WRITE, 32'h0000_0003, 6'd2);
        add_req(REQ_UNUSED, 32'h0, 6'd0);
        add_req(REQ_ALIGN, 32'h0, 6'd0);

        // Random part: mostly writes with random content, with align, flush
        // and ignored requests mixed in.
        counted = 0;
        while (counted < RAND_REQS)
        begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0:       val = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                default: val = $urandom();
            endcase
            if (pick < 70)
            begin
                case ($urandom_range(0, 9))
                    0:       wid = 0;
                    1:       wid = 32;
                    2:       wid = $urandom_range(33, 63);
                    default: wid = $urandom_range(1, 32);
                endcase
                add_req(REQ_WRITE, val, wid[WIDTH_W-1:0], counted == RAND_REQS / 2,
                        counted >= RAND_REQS - 20);
            end
            else if (pick < 82)
            begin
                add_req(REQ_ALIGN, val, WIDTH_W'($urandom_range(0, 63)), 1'b0,
                        counted >= RAND_REQS - 20);
            end
            else if (pick < 95)
            begin
                add_req(REQ_FLUSH, val, WIDTH_W'($urandom_range(0, 63)), 1'b0,
                        counted >= RAND_REQS - 20);
            end
            else
            begin
                add_req(REQ_UNUSED, val, WIDTH_W'($urandom_range(0, 63)), 1'b0,
                        counted >= RAND_REQS - 20);
            end
            counted++;
        end
        add_req(REQ_FLUSH, 32'h0, 6'd0, 1'b0, 1'b1);
        total_reqs = req_q.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (accepted_cnt == total_reqs);
        wait (bytes_due.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb: %0d requests sent (writes, aligns, flushes, ignored codes)", total_reqs);
        $display("tb: %0d output bytes checked, %0d mismatches", checked_cnt, error_cnt);
        if (error_cnt == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/lbp_pkg.sv
hdl/lbp_front.sv
hdl/lbp_queue.sv
hdl/lbp_back.sv
hdl/lsb_first_bit_packer.sv
dv/tb.sv
